// ===== design/cna_pkg.sv =====
package cna_pkg;

  localparam int unsigned DefFracBits = 16;
  localparam int unsigned DataW       = 32;
  // quotient bits kept by the divider; anything at or above 2^QW saturates
  localparam int unsigned QW          = 33;
  localparam int unsigned MidDepth    = 4;
  localparam int unsigned OutDepth    = 2;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_MAG  = 3'd4,
    OP_MAXN = 3'd5,
    OP_EQ   = 3'd6,
    OP_NONE = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIVZERO = 2'd1,
    ST_SAT     = 2'd2
  } status_e;

  typedef struct packed {
    op_e                      operation;
    logic signed [DataW-1:0]  a_re;
    logic signed [DataW-1:0]  a_im;
    logic signed [DataW-1:0]  b_re;
    logic signed [DataW-1:0]  b_im;
  } item_t;

  typedef struct packed {
    logic signed [DataW-1:0]  res_re;
    logic signed [DataW-1:0]  res_im;
    status_e                  status;
  } result_t;

  // beat between front and back: raw products plus the finished simple ops
  typedef struct packed {
    op_e                      op;
    logic signed [63:0]       p_rr;
    logic signed [63:0]       p_ii;
    logic signed [63:0]       p_ri;
    logic signed [63:0]       p_ir;
    logic [63:0]              sq;
    result_t                  simple;
  } mid_t;

  typedef struct packed {
    logic                     sat;
    logic [DataW-1:0]         val;
  } sat_t;

  function automatic sat_t clamp_sm(input logic neg, input logic [64:0] mag);
    sat_t r;
    r.sat = 1'b0;
    if (!neg) begin
      if (mag > 65'h7FFF_FFFF) begin
        r.sat = 1'b1;
        r.val = 32'h7FFF_FFFF;
      end else begin
        r.val = mag[31:0];
      end
    end else if (mag > 65'h8000_0000) begin
      r.sat = 1'b1;
      r.val = 32'h8000_0000;
    end else begin
      r.val = (~mag[31:0]) + 32'd1;
    end
    return r;
  endfunction

  function automatic sat_t clamp_s33(input logic signed [32:0] v);
    logic [32:0] mag;
    mag = v[32] ? 33'(-v) : 33'(v);
    return clamp_sm(v[32], 65'(mag));
  endfunction

endpackage

// ===== design/complex_number_alu.sv =====
// An accepted input beat passes through 2 front stages, the mid queue, 2 setup
// stages, 33 divide/root steps and the output queue before its result is on result_o.
// Throughput: one beat per cycle for every operation unless a full queue stalls;
// Divider and square root are fully pipelined, one quotient/root bit per stage.
// Reset (rst_ni low, async) empties both queues and clears all pipeline valids.
module complex_number_alu import cna_pkg::*; #(
  parameter int unsigned FRAC_BITS = DefFracBits
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push,
  output logic    full,
  input  item_t   item_i,
  output logic    empty,
  input  logic    pop,
  output result_t result_o
);

  logic    mq_full, mq_empty, mq_push, mq_pop;
  mid_t    mq_wdata, mq_rdata;
  logic    oq_full, oq_push;
  result_t oq_wdata;

  cna_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (item_i),
    .full_o   (full),
    .q_full_i (mq_full),
    .q_push_o (mq_push),
    .q_data_o (mq_wdata)
  );

  cna_fifo #(
    .Width ($bits(mid_t)),
    .Depth (MidDepth)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mq_push),
    .data_i  (mq_wdata),
    .full_o  (mq_full),
    .pop_i   (mq_pop),
    .data_o  (mq_rdata),
    .empty_o (mq_empty)
  );

  cna_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (mq_empty),
    .q_data_i   (mq_rdata),
    .q_pop_o    (mq_pop),
    .out_full_i (oq_full),
    .out_push_o (oq_push),
    .out_data_o (oq_wdata)
  );

  cna_fifo #(
    .Width ($bits(result_t)),
    .Depth (OutDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (oq_push),
    .data_i  (oq_wdata),
    .full_o  (oq_full),
    .pop_i   (pop),
    .data_o  (result_o),
    .empty_o (empty)
  );

endmodule

// ===== design/cna_fifo.sv =====
module cna_fifo import cna_pkg::*; #(
  parameter int unsigned Width = $bits(mid_t),
  parameter int unsigned Depth = MidDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = $clog2(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wp_q, rp_q;
  logic [AW:0]      cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == (AW+1)'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= wp_q + AW'(1);
      if (do_pop)  rp_q <= rp_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= data_i;
  end

endmodule

// ===== design/cna_front.sv =====
module cna_front import cna_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  q_full_i,
  output logic  q_push_o,
  output mid_t  q_data_o
);

  logic  v0_q, v1_q, en0, en1;
  item_t it0_q;
  mid_t  mid_q, mid_d;

  logic                     div_sel;
  logic signed [DataW-1:0]  xr, xi;
  logic signed [63:0]       xr2, xi2;
  logic signed [32:0]       ex_r, ex_i;
  logic [32:0]              abs_r, abs_i, mx;
  sat_t                     c_re, c_im;

  assign en1      = !v1_q || !q_full_i;
  assign en0      = !v0_q || en1;
  assign full_o   = !en0;
  assign q_push_o = v1_q && !q_full_i;
  assign q_data_o = mid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (en0) v0_q <= push_i;
      if (en1) v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0 && push_i) it0_q <= item_i;
    if (en1 && v0_q)   mid_q <= mid_d;
  end

  always_comb begin
    div_sel    = it0_q.operation == OP_DIV;
    xr         = div_sel ? it0_q.b_re : it0_q.a_re;
    xi         = div_sel ? it0_q.b_im : it0_q.a_im;
    xr2        = xr * xr;
    xi2        = xi * xi;

    mid_d.op   = it0_q.operation;
    mid_d.p_rr = it0_q.a_re * it0_q.b_re;
    mid_d.p_ii = it0_q.a_im * it0_q.b_im;
    mid_d.p_ri = it0_q.a_re * it0_q.b_im;
    mid_d.p_ir = it0_q.a_im * it0_q.b_re;
    mid_d.sq   = 64'(xr2) + 64'(xi2);

    ex_r  = 33'(it0_q.a_re);
    ex_i  = 33'(it0_q.a_im);
    abs_r = ex_r[32] ? 33'(-ex_r) : 33'(ex_r);
    abs_i = ex_i[32] ? 33'(-ex_i) : 33'(ex_i);
    mx    = (abs_r > abs_i) ? abs_r : abs_i;

    c_re = '0;
    c_im = '0;
    mid_d.simple = '0;
    unique case (it0_q.operation)
      OP_ADD: begin
        c_re = clamp_s33(33'(it0_q.a_re) + 33'(it0_q.b_re));
        c_im = clamp_s33(33'(it0_q.a_im) + 33'(it0_q.b_im));
      end
      OP_SUB: begin
        c_re = clamp_s33(33'(it0_q.a_re) - 33'(it0_q.b_re));
        c_im = clamp_s33(33'(it0_q.a_im) - 33'(it0_q.b_im));
      end
      OP_MAXN: c_re = clamp_sm(1'b0, 65'(mx));
      OP_EQ: begin
        c_re.val = (it0_q.a_re == it0_q.b_re && it0_q.a_im == it0_q.b_im) ? 32'd1 : 32'd0;
      end
      OP_MUL, OP_DIV, OP_MAG, OP_NONE: ;
      default: ;
    endcase
    mid_d.simple.res_re = c_re.val;
    mid_d.simple.res_im = c_im.val;
    mid_d.simple.status = (c_re.sat || c_im.sat) ? ST_SAT : ST_OK;
  end

endmodule

// ===== design/cna_back.sv =====
module cna_back import cna_pkg::*; #(
  parameter int unsigned FRAC_BITS = DefFracBits
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_empty_i,
  input  mid_t    q_data_i,
  output logic    q_pop_o,
  input  logic    out_full_i,
  output logic    out_push_o,
  output result_t out_data_o
);

  localparam int unsigned NSteps = QW;
  localparam int unsigned ShR    = QW - FRAC_BITS;

  typedef struct packed {
    op_e         op;
    logic        neg_re;
    logic        neg_im;
    logic [63:0] mag_re;
    logic [63:0] mag_im;
    logic [63:0] sq;
    result_t     simple;
  } b0_t;

  typedef struct packed {
    op_e          op;
    logic         neg_re;
    logic         neg_im;
    logic         big_re;
    logic         big_im;
    logic         dz;
    logic [63:0]  rem_re;
    logic [63:0]  rem_im;
    logic [63:0]  den;
    logic [QW-1:0] lo_re;
    logic [QW-1:0] lo_im;
    logic [QW-1:0] q_re;
    logic [QW-1:0] q_im;
    logic [65:0]  sx;
    logic [33:0]  srem;
    logic [32:0]  root;
    result_t      simple;
  } step_t;

  // one quotient bit of each divider and one root bit per stage
  function automatic step_t do_step(input step_t s);
    logic [64:0] t_re, t_im;
    logic [35:0] st, trial;
    step_t       r;
    r = s;
    if (s.op == OP_DIV) begin
      t_re = {s.rem_re, s.lo_re[QW-1]};
      t_im = {s.rem_im, s.lo_im[QW-1]};
      if (t_re >= {1'b0, s.den}) begin
        r.rem_re = 64'(t_re - {1'b0, s.den});
        r.q_re   = {s.q_re[QW-2:0], 1'b1};
      end else begin
        r.rem_re = t_re[63:0];
        r.q_re   = {s.q_re[QW-2:0], 1'b0};
      end
      if (t_im >= {1'b0, s.den}) begin
        r.rem_im = 64'(t_im - {1'b0, s.den});
        r.q_im   = {s.q_im[QW-2:0], 1'b1};
      end else begin
        r.rem_im = t_im[63:0];
        r.q_im   = {s.q_im[QW-2:0], 1'b0};
      end
      r.lo_re = {s.lo_re[QW-2:0], 1'b0};
      r.lo_im = {s.lo_im[QW-2:0], 1'b0};
    end
    if (s.op == OP_MAG) begin
      st    = {s.srem, s.sx[65:64]};
      trial = {1'b0, s.root, 2'b01};
      if (st >= trial) begin
        r.srem = 34'(st - trial);
        r.root = {s.root[31:0], 1'b1};
      end else begin
        r.srem = st[33:0];
        r.root = {s.root[31:0], 1'b0};
      end
      r.sx = {s.sx[63:0], 2'b00};
    end
    return r;
  endfunction

  logic               adv;
  logic               b0_v_q, b1_v_q;
  logic [NSteps-1:0]  sv_q;
  b0_t                b0_q, b0_d;
  step_t              b1_q, b1_d;
  step_t              sp_q [NSteps];

  logic               div_sel;
  logic signed [64:0] re_s, im_s, pii, pri;
  logic [63:0]        sh_re, sh_im;
  step_t              last;
  sat_t               c_re, c_im;

  assign adv        = !(sv_q[NSteps-1] && out_full_i);
  assign q_pop_o    = adv && !q_empty_i;
  assign out_push_o = sv_q[NSteps-1] && !out_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_v_q <= 1'b0;
      b1_v_q <= 1'b0;
      sv_q   <= '0;
    end else if (adv) begin
      b0_v_q <= !q_empty_i;
      b1_v_q <= b0_v_q;
      sv_q   <= {sv_q[NSteps-2:0], b1_v_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b0_q <= b0_d;
      b1_q <= b1_d;
    end
  end

  for (genvar k = 0; k < NSteps; k++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (adv) sp_q[k] <= do_step((k == 0) ? b1_q : sp_q[(k == 0) ? 0 : k-1]);
    end
  end

  // signed sums of the product pairs, kept as sign and magnitude
  always_comb begin
    div_sel = q_data_i.op == OP_DIV;
    pii     = 65'(q_data_i.p_ii);
    pri     = 65'(q_data_i.p_ri);
    re_s    = 65'(q_data_i.p_rr) + (div_sel ? pii : -pii);
    im_s    = 65'(q_data_i.p_ir) + (div_sel ? -pri : pri);
    b0_d.op     = q_data_i.op;
    b0_d.neg_re = re_s[64];
    b0_d.neg_im = im_s[64];
    b0_d.mag_re = re_s[64] ? 64'(-re_s) : 64'(re_s);
    b0_d.mag_im = im_s[64] ? 64'(-im_s) : 64'(im_s);
    b0_d.sq     = q_data_i.sq;
    b0_d.simple = q_data_i.simple;
  end

  // divider and root setup: top part of (num << FRAC_BITS) seeds the divider remainder
  always_comb begin
    sh_re       = b0_q.mag_re >> ShR;
    sh_im       = b0_q.mag_im >> ShR;
    b1_d.op     = b0_q.op;
    b1_d.neg_re = b0_q.neg_re;
    b1_d.neg_im = b0_q.neg_im;
    b1_d.big_re = sh_re >= b0_q.sq;
    b1_d.big_im = sh_im >= b0_q.sq;
    b1_d.dz     = b0_q.sq == '0;
    b1_d.den    = b0_q.sq;
    b1_d.rem_re = (b0_q.op == OP_DIV) ? sh_re : b0_q.mag_re;
    b1_d.rem_im = (b0_q.op == OP_DIV) ? sh_im : b0_q.mag_im;
    b1_d.lo_re  = QW'(b0_q.mag_re << FRAC_BITS);
    b1_d.lo_im  = QW'(b0_q.mag_im << FRAC_BITS);
    b1_d.q_re   = '0;
    b1_d.q_im   = '0;
    b1_d.sx     = {2'b00, b0_q.sq};
    b1_d.srem   = '0;
    b1_d.root   = '0;
    b1_d.simple = b0_q.simple;
  end

  always_comb begin
    last       = sp_q[NSteps-1];
    c_re       = '0;
    c_im       = '0;
    out_data_o = last.simple;
    unique case (last.op)
      OP_MUL: begin
        c_re = clamp_sm(last.neg_re, 65'(last.rem_re >> FRAC_BITS));
        c_im = clamp_sm(last.neg_im, 65'(last.rem_im >> FRAC_BITS));
        out_data_o.res_re = c_re.val;
        out_data_o.res_im = c_im.val;
        out_data_o.status = (c_re.sat || c_im.sat) ? ST_SAT : ST_OK;
      end
      OP_DIV: begin
        if (last.dz) begin
          out_data_o.res_re = '0;
          out_data_o.res_im = '0;
          out_data_o.status = ST_DIVZERO;
        end else begin
          c_re = clamp_sm(last.neg_re, last.big_re ? (65'd1 << QW) : 65'(last.q_re));
          c_im = clamp_sm(last.neg_im, last.big_im ? (65'd1 << QW) : 65'(last.q_im));
          out_data_o.res_re = c_re.val;
          out_data_o.res_im = c_im.val;
          out_data_o.status = (c_re.sat || c_im.sat) ? ST_SAT : ST_OK;
        end
      end
      OP_MAG: begin
        c_re = clamp_sm(1'b0, 65'(last.root));
        out_data_o.res_re = c_re.val;
        out_data_o.res_im = '0;
        out_data_o.status = c_re.sat ? ST_SAT : ST_OK;
      end
      default: out_data_o = last.simple;
    endcase
  end

endmodule
